// File: sv/volume_backward_warp_trilinear_unit_assert.svh
// Assertion macros for the warp unit; clk and rst_n must be in scope.
`ifndef VOLUME_BACKWARD_WARP_TRILINEAR_UNIT_ASSERT_SVH
`define VOLUME_BACKWARD_WARP_TRILINEAR_UNIT_ASSERT_SVH

// Condition must never hold outside reset
`define VBWT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vbwt: forbidden condition seen");

// Consequent must hold in the cycle after the antecedent
`define VBWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vbwt: expected follow-up missing");

`endif

// File: sv/vbwt_pkg.sv
`timescale 1ns / 1ps
package vbwt_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_DEPTH  = 64;
  localparam int CW         = 6;   // coordinate width of the item fields
  localparam int DW         = 7;   // dimension register width
  localparam int VW         = 16;  // voxel width
  localparam int NBANK      = 8;   // one bank per coordinate parity triple
  localparam int BAW        = 3 * (CW - 1);
  localparam int BDEPTH     = 1 << BAW;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_INV_X  = 3'd3;
  localparam logic [2:0] REG_INV_Y  = 3'd4;
  localparam logic [2:0] REG_INV_Z  = 3'd5;

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WARP = 1'b1;

  typedef struct packed {
    logic           en;
    logic           we;
    logic [BAW-1:0] addr;
    logic [VW-1:0]  wdata;
  } ram_ctl_t;

  // Dimension register clamped to 1 ..= max
  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] r, input logic [DW-1:0] mx);
    logic [DW-1:0] d;
    d = r;
    if (r == '0) d = DW'(1);
    else if (r > mx) d = mx;
    return d;
  endfunction

  // pos*256 + round(prod / 4096), signed Q.8
  function automatic logic signed [25:0] displace(input logic [CW-1:0] pos,
                                                  input logic signed [36:0] prod);
    logic signed [36:0] t;
    logic signed [25:0] d;
    t = prod + 37'sd2048;
    d = {t[36], t[36:12]};
    return $signed({12'b0, pos, 8'b0}) + d;
  endfunction

  // 0 <= p <= (dim-1)*256
  function automatic logic in_range(input logic signed [25:0] p, input logic [DW-1:0] dim);
    logic [DW-1:0] dm1;
    dm1 = dim - DW'(1);
    return !p[25] && (p[24:0] <= {10'b0, dm1, 8'b0});
  endfunction

endpackage

// File: sv/vbwt_ram.sv
`timescale 1ns / 1ps
module vbwt_ram (
  input  logic              clk,
  input  vbwt_pkg::ram_ctl_t ctl,
  output logic [15:0]       rdata_r
);
  import vbwt_pkg::*;

  logic [VW-1:0] mem [0:BDEPTH-1];

  // single port, registered read, read-before-write
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[ctl.addr] <= ctl.wdata;
      end
      rdata_r <= mem[ctl.addr];
    end
  end

endmodule

// File: sv/volume_backward_warp_trilinear_unit.sv
`timescale 1ns / 1ps
// channel | handshake          | payload
// in      | in_valid/in_stall  | operation, pos_x/y/z, voxel_value, flow_x/y/z
// out     | out_valid/out_stall| warped_value, out_of_range (one per warp item)
// cfg     | cfg_we             | cfg_index, cfg_wdata
// One item may enter every cycle unless in_stall is high; results are registered at the output.
// The store is eight single-port banks split by coordinate parity, so all eight
// neighbours are read in the same cycle and a load takes the same port slot.
// Reset (synchronous) empties the pipeline and restores the registers; the store is not cleared.
// Stalls back up stage by stage, so bubbles are squeezed out and nothing is lost.
module volume_backward_warp_trilinear_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [5:0]               in_pos_x,
  input  logic [5:0]               in_pos_y,
  input  logic [5:0]               in_pos_z,
  input  logic [15:0]              in_voxel_value,
  input  logic signed [19:0]       in_flow_x,
  input  logic signed [19:0]       in_flow_y,
  input  logic signed [19:0]       in_flow_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              out_warped_value,
  output logic                     out_out_of_range,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_wdata
);
  import vbwt_pkg::*;

  // configuration registers
  logic [DW-1:0] width_r, height_r, depth_r;
  logic [15:0]   inv_x_r, inv_y_r, inv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(64);
      height_r <= DW'(64);
      depth_r  <= DW'(64);
      inv_x_r  <= 16'd4096;
      inv_y_r  <= 16'd4096;
      inv_z_r  <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[DW-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[DW-1:0];
        REG_DEPTH:  depth_r  <= cfg_wdata[DW-1:0];
        REG_INV_X:  inv_x_r  <= cfg_wdata;
        REG_INV_Y:  inv_y_r  <= cfg_wdata;
        REG_INV_Z:  inv_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] wd, hd, dd;
  assign wd = eff_dim(width_r,  DW'(MAX_WIDTH));
  assign hd = eff_dim(height_r, DW'(MAX_HEIGHT));
  assign dd = eff_dim(depth_r,  DW'(MAX_DEPTH));

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  assign rdy7 = !v7_r || !out_stall;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: flow times inverse step
  logic               op1_r;
  logic [CW-1:0]      px1_r, py1_r, pz1_r;
  logic [VW-1:0]      v01_r;
  logic signed [36:0] prx1_r, pry1_r, prz1_r;
  logic signed [36:0] prx_nxt, pry_nxt, prz_nxt;
  assign prx_nxt = in_flow_x * $signed({1'b0, inv_x_r});
  assign pry_nxt = in_flow_y * $signed({1'b0, inv_y_r});
  assign prz_nxt = in_flow_z * $signed({1'b0, inv_z_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (rdy1) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r  <= in_operation;
      px1_r  <= in_pos_x;
      py1_r  <= in_pos_y;
      pz1_r  <= in_pos_z;
      v01_r  <= in_voxel_value;
      prx1_r <= prx_nxt;
      pry1_r <= pry_nxt;
      prz1_r <= prz_nxt;
    end
  end

  // stage 2: displaced position, range test, base index and fraction
  logic signed [25:0] xf, yf, zf;
  logic               oor_nxt;
  assign xf = displace(px1_r, prx1_r);
  assign yf = displace(py1_r, pry1_r);
  assign zf = displace(pz1_r, prz1_r);
  assign oor_nxt = !(in_range(xf, wd) && in_range(yf, hd) && in_range(zf, dd));

  logic          op2_r, oor2_r;
  logic [CW-1:0] x02_r, y02_r, z02_r;
  logic [7:0]    fx2_r, fy2_r, fz2_r;
  logic [VW-1:0] v02_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (rdy2) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (rdy2) begin
      op2_r  <= op1_r;
      oor2_r <= oor_nxt;
      v02_r  <= v01_r;
      fx2_r  <= xf[7:0];
      fy2_r  <= yf[7:0];
      fz2_r  <= zf[7:0];
      // a load addresses its own voxel
      x02_r  <= (op1_r == OP_WARP) ? xf[13:8] : px1_r;
      y02_r  <= (op1_r == OP_WARP) ? yf[13:8] : py1_r;
      z02_r  <= (op1_r == OP_WARP) ? zf[13:8] : pz1_r;
    end
  end

  // stage 3: bank access and per-parity weights
  ram_ctl_t      ctl [NBANK];
  logic [VW-1:0] rdata [NBANK];
  logic [8:0]    wxs [2];
  logic [8:0]    wys [2];
  logic [8:0]    wzs [2];
  logic          ram_en;
  assign ram_en = rdy3 && v2_r;

  always_comb begin
    logic [CW-1:0] cx, cy, cz;
    for (int b = 0; b < NBANK; b++) begin
      cx = (x02_r[0] == b[0]) ? x02_r : x02_r + CW'(1);
      cy = (y02_r[0] == b[1]) ? y02_r : y02_r + CW'(1);
      cz = (z02_r[0] == b[2]) ? z02_r : z02_r + CW'(1);
      ctl[b].en    = ram_en;
      ctl[b].we    = (op2_r == OP_LOAD) && ({z02_r[0], y02_r[0], x02_r[0]} == b[2:0]);
      ctl[b].addr  = {cz[CW-1:1], cy[CW-1:1], cx[CW-1:1]};
      ctl[b].wdata = v02_r;
    end
    for (int p = 0; p < 2; p++) begin
      wxs[p] = (x02_r[0] == p[0]) ? 9'd256 - {1'b0, fx2_r} : {1'b0, fx2_r};
      wys[p] = (y02_r[0] == p[0]) ? 9'd256 - {1'b0, fy2_r} : {1'b0, fy2_r};
      wzs[p] = (z02_r[0] == p[0]) ? 9'd256 - {1'b0, fz2_r} : {1'b0, fz2_r};
    end
  end

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    vbwt_ram u_ram (
      .clk     (clk),
      .ctl     (ctl[g]),
      .rdata_r (rdata[g])
    );
  end

  logic          oor3_r;
  logic [VW-1:0] v03_r;
  logic [17:0]   wxy3_r [4];
  logic [8:0]    wz3_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (rdy3) v3_r <= v2_r && (op2_r == OP_WARP);
  end
  always_ff @(posedge clk) begin
    if (rdy3) begin
      oor3_r <= oor2_r;
      v03_r  <= v02_r;
      for (int q = 0; q < 4; q++) begin
        wxy3_r[q] <= wxs[q % 2] * wys[q / 2];
      end
      wz3_r[0] <= wzs[0];
      wz3_r[1] <= wzs[1];
    end
  end

  // stage 4: full corner weights
  logic          oor4_r;
  logic [VW-1:0] v04_r;
  logic [24:0]   w4_r [NBANK];
  logic [VW-1:0] vox4_r [NBANK];
  logic [26:0]   wfull [NBANK];

  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      wfull[b] = wxy3_r[b % 4] * wz3_r[b / 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (rdy4) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (rdy4) begin
      oor4_r <= oor3_r;
      v04_r  <= v03_r;
      for (int b = 0; b < NBANK; b++) begin
        w4_r[b]   <= wfull[b][24:0];
        vox4_r[b] <= rdata[b];
      end
    end
  end

  // stage 5: weighted voxels; a zero weight drops its voxel entirely
  logic          oor5_r;
  logic [VW-1:0] v05_r;
  logic [40:0]   pr5_r [NBANK];

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (rdy5) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (rdy5) begin
      oor5_r <= oor4_r;
      v05_r  <= v04_r;
      for (int b = 0; b < NBANK; b++) begin
        pr5_r[b] <= (w4_r[b] == '0) ? 41'd0 : w4_r[b] * vox4_r[b];
      end
    end
  end

  // stage 6: pair sums
  logic          oor6_r;
  logic [VW-1:0] v06_r;
  logic [41:0]   ps6_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (rdy6) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (rdy6) begin
      oor6_r <= oor5_r;
      v06_r  <= v05_r;
      for (int q = 0; q < 4; q++) begin
        ps6_r[q] <= {1'b0, pr5_r[2*q]} + {1'b0, pr5_r[2*q+1]};
      end
    end
  end

  // stage 7: final sum, rounding, output register; an out-of-range item returns its input voxel
  logic [43:0] total;
  logic [15:0] res_r;
  logic        oor7_r;
  assign total = {2'b0, ps6_r[0]} + {2'b0, ps6_r[1]} + {2'b0, ps6_r[2]}
               + {2'b0, ps6_r[3]} + 44'd8388608;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (rdy7) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (rdy7) begin
      oor7_r <= oor6_r;
      res_r  <= oor6_r ? v06_r : total[39:24];
    end
  end

  assign out_valid        = v7_r;
  assign out_warped_value = res_r;
  assign out_out_of_range = oor7_r;

  // checks
  `include "volume_backward_warp_trilinear_unit_assert.svh"
  `VBWT_ASSERT_NEVER(a_stall_needs_item, in_stall && !v1_r)
  `VBWT_ASSERT_NEVER(a_ram_only_on_move, ram_en && !rdy3)
  `VBWT_ASSERT_NEXT(a_load_leaves, v2_r && (op2_r == OP_LOAD) && rdy3, !v3_r)

endmodule
